FILE: hw/rtl/sef_pkg.sv
`default_nettype none

package sef_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 13;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 12;
    localparam int GRAD_W     = 11;
    localparam int HEIGHT_MAX = 4096;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;
    localparam int GEOM_MIN   = 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic signed [GRAD_W-1:0] t_grad;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_GRADIENT_MODE = 2'd2
    } t_cfg_index;

    // 3x3 neighborhood without the center tap, which Sobel does not use.
    typedef struct packed {
        t_pixel lt;
        t_pixel lm;
        t_pixel lb;
        t_pixel ct;
        t_pixel cb;
        t_pixel rt;
        t_pixel rm;
        t_pixel rb;
    } t_window;

endpackage

`default_nettype wire

FILE: hw/rtl/sobel_edge_filter.sv
`default_nettype none

// Channel    Direction  Handshake           Payload
// pixel in   input      i_valid / o_stall   i_pixel
// result     output     o_valid / i_stall   o_edge_value, o_out_row, o_out_col, o_frame_end
// config     input      i_cfg_we            i_cfg_index, i_cfg_data
//
// One pixel per clock unless o_stall is set; stage one, two and the output are registered.
// The line buffer read is registered, so stage one waits for the memory port.
// Reset is synchronous and active low and needs no clearing pass over the line buffers.
// Each stage holds its transaction while blocked; bubbles close up under output stall.

module sobel_edge_filter import sef_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire t_pixel           i_pixel,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_pixel                o_edge_value,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [COL_W-1:0]      o_out_col,
    output logic                  o_frame_end,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > CFG_W) ? WW : CFG_W;
    localparam int WIDTH_RST_EFF = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    localparam int SQ_W = 2 * GRAD_W;

    logic [EW-1:0]    r_width_eff;
    logic [CFG_W-1:0] r_height_eff;
    logic             r_mode;
    logic [EW-1:0]    n_width_eff;
    logic [CFG_W-1:0] n_height_eff;

    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             col_last;
    logic             row_last;

    logic             r_s1_valid;
    logic [AW-1:0]    r_s1_addr;
    t_pixel           r_s1_pix;
    logic             r_s1_emit;
    logic             r_s1_zero;
    logic             r_s1_last;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;

    t_pixel           r_lt, r_lm, r_lb, r_ct, r_cm, r_cb;
    t_pixel           mem_top;
    t_pixel           mem_mid;
    t_window          win;
    t_grad            gx;
    t_grad            gy;

    logic             r_s2_valid;
    t_grad            r_s2_gx;
    t_grad            r_s2_gy;
    logic             r_s2_zero;
    logic             r_s2_last;
    logic [ROW_W-1:0] r_s2_row;
    logic [COL_W-1:0] r_s2_col;

    logic             r_o_valid;
    t_pixel           r_o_value;
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_col;
    logic             r_o_last;

    logic             accept;
    logic             out_free;
    logic             s2_free;
    logic             s2_move;
    logic             s1_go;
    logic             s1_load;

    logic [GRAD_W-2:0]   abs_x;
    logic [GRAD_W-2:0]   abs_y;
    logic signed [GRAD_W-1:0] diff;
    logic signed [SQ_W-1:0]   sq_x;
    logic signed [SQ_W-1:0]   sq_y;
    logic [SQ_W:0]       sq_sum;
    t_pixel              value;

    // Geometry is clamped when written so the datapath only sees legal sizes.
    always_comb begin
        n_width_eff = EW'(i_cfg_data);
        if (i_cfg_data < CFG_W'(GEOM_MIN)) begin
            n_width_eff = EW'(GEOM_MIN);
        end else if (EW'(i_cfg_data) > EW'(MAX_WIDTH)) begin
            n_width_eff = EW'(MAX_WIDTH);
        end
        n_height_eff = i_cfg_data;
        if (i_cfg_data < CFG_W'(GEOM_MIN)) begin
            n_height_eff = CFG_W'(GEOM_MIN);
        end else if (i_cfg_data > CFG_W'(HEIGHT_MAX)) begin
            n_height_eff = CFG_W'(HEIGHT_MAX);
        end
    end

    assign out_free = !r_o_valid || !i_stall;
    assign s2_free  = !r_s2_valid || out_free;
    assign s2_move  = r_s2_valid && out_free;
    assign s1_go    = r_s1_valid && (!r_s1_emit || s2_free);
    assign s1_load  = s1_go && r_s1_emit;
    assign o_stall  = r_s1_valid && !s1_go;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        col_cur = r_col;
        if (EW'(r_col) >= r_width_eff) begin
            col_cur = '0;
        end
        row_cur = r_row;
        if (CFG_W'(r_row) >= r_height_eff) begin
            row_cur = '0;
        end
        col_last = (EW'(col_cur) + EW'(1)) >= r_width_eff;
        row_last = (CFG_W'(row_cur) + CFG_W'(1)) >= r_height_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_eff  <= EW'(WIDTH_RST_EFF);
            r_height_eff <= CFG_W'(HEIGHT_RST);
            r_mode       <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH: begin
                    r_width_eff <= n_width_eff;
                    r_col       <= '0;
                    r_row       <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_height_eff <= n_height_eff;
                    r_col        <= '0;
                    r_row        <= '0;
                end
                CFG_GRADIENT_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : row_cur + ROW_W'(1);
            end else begin
                r_col <= col_cur + AW'(1);
                r_row <= row_cur;
            end
        end
    end

    sef_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col_cur),
        .o_top     (mem_top),
        .o_mid     (mem_mid),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_mid  (mem_mid),
        .i_wr_pix  (r_s1_pix)
    );

    // Stage one: position bookkeeping; the window meets the line buffer output here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= col_cur;
            r_s1_pix  <= i_pixel;
            r_s1_emit <= (row_cur != '0) && (col_cur != '0);
            r_s1_zero <= (row_cur == ROW_W'(1)) || (col_cur == AW'(1));
            r_s1_last <= row_last && col_last;
            r_s1_row  <= row_cur - ROW_W'(1);
            r_s1_col  <= COL_W'(col_cur - AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= '0;
            r_lm <= '0;
            r_lb <= '0;
            r_ct <= '0;
            r_cm <= '0;
            r_cb <= '0;
        end else if (s1_go) begin
            r_lt <= r_ct;
            r_lm <= r_cm;
            r_lb <= r_cb;
            r_ct <= mem_top;
            r_cm <= mem_mid;
            r_cb <= r_s1_pix;
        end
    end

    assign win = '{lt: r_lt, lm: r_lm, lb: r_lb, ct: r_ct, cb: r_cb,
                   rt: mem_top, rm: mem_mid, rb: r_s1_pix};

    sef_kernel u_kernel (
        .i_win (win),
        .o_gx  (gx),
        .o_gy  (gy)
    );

    // Stage two: gradients are registered, the combine and clamp follow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_load) begin
            r_s2_valid <= 1'b1;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s2_gx   <= gx;
            r_s2_gy   <= gy;
            r_s2_zero <= r_s1_zero;
            r_s2_last <= r_s1_last;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
        end
    end

    always_comb begin
        abs_x  = r_s2_gx[GRAD_W-1] ? (GRAD_W-1)'(-r_s2_gx) : (GRAD_W-1)'(r_s2_gx);
        abs_y  = r_s2_gy[GRAD_W-1] ? (GRAD_W-1)'(-r_s2_gy) : (GRAD_W-1)'(r_s2_gy);
        diff   = t_grad'({1'b0, abs_x}) - t_grad'({1'b0, abs_y});
        sq_x   = r_s2_gx * r_s2_gx;
        sq_y   = r_s2_gy * r_s2_gy;
        sq_sum = (SQ_W + 1)'($unsigned(sq_x)) + (SQ_W + 1)'($unsigned(sq_y));
        value  = '0;
        if (r_s2_zero) begin
            value = '0;
        end else if (r_mode) begin
            value = (sq_sum > (SQ_W + 1)'(PIX_MAX)) ? PIX_MAX : PIX_W'(sq_sum);
        end else if (diff < 0) begin
            value = '0;
        end else if (diff > t_grad'(PIX_MAX)) begin
            value = PIX_MAX;
        end else begin
            value = PIX_W'(diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_o_value <= value;
            r_o_row   <= r_s2_row;
            r_o_col   <= r_s2_col;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_edge_value = r_o_value;
    assign o_out_row    = r_o_row;
    assign o_out_col    = r_o_col;
    assign o_frame_end  = r_o_last;

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_row == '0 || o_out_col == '0) |-> o_edge_value == '0)
        else $error("nonzero result on the top row or left column");

    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_stall)
        else $error("input stalled while stage one is empty");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_o_valid && i_stall |=> r_s2_valid && $stable(r_s2_row)
            && $stable(r_s2_col))
        else $error("stage two transaction lost under output stall");

endmodule

`default_nettype wire

FILE: hw/rtl/sef_line_buffer.sv
`default_nettype none

module sef_line_buffer import sef_pkg::*; #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_pixel             o_top,
    output t_pixel             o_mid,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_pixel        i_wr_mid,
    input  wire t_pixel        i_wr_pix
);

    // Store A holds the previous row, store B the row before it.
    t_pixel r_store_a [DEPTH];
    t_pixel r_store_b [DEPTH];
    t_pixel r_rd_top;
    t_pixel r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store_a[i_wr_addr] <= i_wr_pix;
            r_store_b[i_wr_addr] <= i_wr_mid;
        end
        if (i_rd_en) begin
            r_rd_top <= r_store_b[i_rd_addr];
            r_rd_mid <= r_store_a[i_rd_addr];
        end
    end

    assign o_top = r_rd_top;
    assign o_mid = r_rd_mid;

endmodule

`default_nettype wire

FILE: hw/rtl/sef_kernel.sv
`default_nettype none

module sef_kernel import sef_pkg::*; (
    input  wire t_window i_win,
    output t_grad        o_gx,
    output t_grad        o_gy
);

    logic [PIX_W+1:0] left;
    logic [PIX_W+1:0] right;
    logic [PIX_W+1:0] top;
    logic [PIX_W+1:0] bottom;

    always_comb begin
        left   = {2'b00, i_win.lt} + {1'b0, i_win.lm, 1'b0} + {2'b00, i_win.lb};
        right  = {2'b00, i_win.rt} + {1'b0, i_win.rm, 1'b0} + {2'b00, i_win.rb};
        top    = {2'b00, i_win.lt} + {1'b0, i_win.ct, 1'b0} + {2'b00, i_win.rt};
        bottom = {2'b00, i_win.lb} + {1'b0, i_win.cb, 1'b0} + {2'b00, i_win.rb};
    end

    assign o_gx = t_grad'({1'b0, left}) - t_grad'({1'b0, right});
    assign o_gy = t_grad'({1'b0, top}) - t_grad'({1'b0, bottom});

endmodule

`default_nettype wire
